// ===== rtl/atcc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atcc_pkg
// Shared types and constants of the text-console cell engine.
// ----------------------------------------------------------------------------
package atcc_pkg;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCROLL,
        ST_FILL,
        ST_DONE
    } state_t;

    // Escape parser phases
    typedef logic [1:0] esc_phase_t;
    localparam esc_phase_t ESC_IDLE = 2'd0;
    localparam esc_phase_t ESC_SEEN = 2'd1;
    localparam esc_phase_t ESC_CSI  = 2'd2;

    // Character codes
    localparam logic [7:0] CH_ESC      = 8'h1B;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_SEMI     = 8'h3B;
    localparam logic [7:0] CH_HOME     = 8'h48;
    localparam logic [7:0] CH_ERASE    = 8'h4A;
    localparam logic [7:0] CH_NL       = 8'h0A;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_BS       = 8'h08;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_DIGIT_0  = 8'h30;
    localparam logic [7:0] CH_DIGIT_9  = 8'h39;

    localparam logic [15:0] ERASE_KEEP_PARAM = 16'd3;
    localparam logic [19:0] NUM_SAT          = 20'd65535;

    // Configuration port
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_COLUMNS_IN_USE = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ROWS_IN_USE    = 1'd1;
    localparam logic [7:0] COLUMNS_RESET = 8'd80;
    localparam logic [6:0] ROWS_RESET    = 7'd25;

    // Result field widths
    localparam int ROW_OUT_W   = 6;
    localparam int COL_OUT_W   = 7;
    localparam int GLYPH_W     = 8;
    localparam int M_TDATA_W   = 40;
    localparam int M_TDATA_PAD = M_TDATA_W - (2 * ROW_OUT_W + 2 * COL_OUT_W + GLYPH_W + 2);

endpackage

// ===== rtl/ansi_text_console_cells_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ansi_text_console_cells_core
// Text-console cell engine: escape parser, cursor and a character-cell memory.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one character byte per transfer; m_* returns one result per
//   byte: the cell written (if any), scroll and clear flags, and the cursor.
//   cfg_* writes columns_in_use (index 0) and rows_in_use (index 1); it is
//   always ready and is meant to be written while no byte is in flight.
// Sequence:
//   A plain byte goes from accept through ST_EXEC, which does the single cell
//   write, to ST_DONE, which loads the output register. A scroll copies each
//   in-use row below the first one row up, then blanks the last row (just
//   that with a single row); an erase-display blanks the in-use area. Both walk
//   the cell memory one cell per cycle through its single write port, the fill
//   waiting out a pending copy write; copies read through the registered port.
// Reset:
//   aresetn clears control state and starts a pass that fills the cell memory
//   (MAX_ROWS by MAX_COLUMNS cells, all of it at the defaults) with spaces;
//   s_tready stays low until it ends. Configuration writes are taken meanwhile.
// Backpressure:
//   The result waits in the output register while m_tready is low; the next
//   byte is still accepted, and its result is held until the register frees.
// ----------------------------------------------------------------------------
module ansi_text_console_cells_core #(
    parameter int MAX_COLUMNS = 128,
    parameter int MAX_ROWS    = 64
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // input channel
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [7:0]                           s_tdata,   // [7:0] char_byte
    // result channel
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [5:0] write_row, [12:6] write_column, [20:13] write_glyph, [21] scrolled,
    // [22] cleared, [28:23] cursor_row_out, [35:29] cursor_column_out, [39:36] 0
    output logic [atcc_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic                                 m_tuser,   // [0] cell_written
    // configuration
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [atcc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [atcc_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int CW        = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int RW        = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int MEM_DEPTH = 2 ** (RW + CW);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    atcc_pkg::state_t       state_reg, state_next;
    logic [7:0]             columns_in_use_reg;
    logic [6:0]             rows_in_use_reg;
    logic [7:0]             ch_reg;
    logic [RW-1:0]          cursor_row_reg, cursor_row_next;
    logic [CW-1:0]          cursor_col_reg, cursor_col_next;
    atcc_pkg::esc_phase_t   phase_reg, phase_next;
    logic [15:0]            number_reg, number_next;
    logic [RW-1:0]          scan_row_reg, scan_row_next;
    logic [CW-1:0]          scan_col_reg, scan_col_next;
    logic [RW-1:0]          fill_row_last_reg, fill_row_last_next;
    logic [CW-1:0]          fill_col_last_reg, fill_col_last_next;
    logic                   init_done_reg, init_done_next;
    logic                   wr_pend_reg, wr_pend_next;
    logic [RW-1:0]          wr_row_reg;
    logic [CW-1:0]          wr_col_reg;
    logic [7:0]             rd_data_reg;
    logic                   res_written_reg;
    logic [atcc_pkg::ROW_OUT_W-1:0] res_row_reg;
    logic [atcc_pkg::COL_OUT_W-1:0] res_col_reg;
    logic [atcc_pkg::GLYPH_W-1:0]   res_glyph_reg;
    logic                   res_scrolled_reg;
    logic                   res_cleared_reg;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [atcc_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic                   m_tuser_reg;

    logic [7:0]             cell_mem [MEM_DEPTH];

    // ------------------------------------------------------------------
    // Effective geometry (last in-use row and column)
    // ------------------------------------------------------------------
    logic [RW-1:0] rows_last;
    logic [CW-1:0] cols_last;

    always_comb begin
        if (rows_in_use_reg == 7'd0) begin
            rows_last = '0;
        end else if (32'(rows_in_use_reg) > MAX_ROWS) begin
            rows_last = RW'(MAX_ROWS - 1);
        end else begin
            rows_last = RW'(rows_in_use_reg - 7'd1);
        end
        if (columns_in_use_reg == 8'd0) begin
            cols_last = '0;
        end else if (32'(columns_in_use_reg) > MAX_COLUMNS) begin
            cols_last = CW'(MAX_COLUMNS - 1);
        end else begin
            cols_last = CW'(columns_in_use_reg - 8'd1);
        end
    end

    // ------------------------------------------------------------------
    // Byte execution
    // ------------------------------------------------------------------
    logic [RW-1:0]         ex_cur_r, ex_new_r, ex_w_r;
    logic [CW-1:0]         ex_cur_c, ex_new_c, ex_w_c;
    logic [7:0]            ex_w_g;
    logic                  ex_we, ex_scroll, ex_clear;
    atcc_pkg::esc_phase_t  ex_phase;
    logic [15:0]           ex_number;

    always_comb begin
        logic        handled;
        logic        home;
        logic        do_adv;
        logic [19:0] prod;

        handled   = 1'b0;
        home      = 1'b0;
        do_adv    = 1'b0;
        ex_clear  = 1'b0;
        ex_scroll = 1'b0;
        ex_we     = 1'b0;
        ex_phase  = phase_reg;
        ex_number = number_reg;
        prod      = ({4'd0, number_reg} << 3) + ({4'd0, number_reg} << 1)
                  + {12'd0, ch_reg - atcc_pkg::CH_DIGIT_0};

        // clamp the cursor in case the geometry shrank
        ex_cur_r = (cursor_row_reg > rows_last) ? rows_last : cursor_row_reg;
        ex_cur_c = (cursor_col_reg > cols_last) ? cols_last : cursor_col_reg;

        case (phase_reg)
            atcc_pkg::ESC_SEEN: begin
                if (ch_reg == atcc_pkg::CH_LBRACKET) begin
                    ex_phase  = atcc_pkg::ESC_CSI;
                    ex_number = '0;
                    handled   = 1'b1;
                end else begin
                    ex_phase = atcc_pkg::ESC_IDLE;
                end
            end
            atcc_pkg::ESC_CSI: begin
                handled = 1'b1;
                if (ch_reg >= atcc_pkg::CH_DIGIT_0 && ch_reg <= atcc_pkg::CH_DIGIT_9) begin
                    ex_number = (prod > atcc_pkg::NUM_SAT) ? 16'hFFFF : prod[15:0];
                end else if (ch_reg == atcc_pkg::CH_SEMI) begin
                    ex_number = '0;
                end else begin
                    if (ch_reg == atcc_pkg::CH_HOME) begin
                        home = 1'b1;
                    end else if (ch_reg == atcc_pkg::CH_ERASE &&
                                 number_reg != atcc_pkg::ERASE_KEEP_PARAM) begin
                        ex_clear = 1'b1;
                    end
                    ex_phase  = atcc_pkg::ESC_IDLE;
                    ex_number = '0;
                end
            end
            default: begin
                if (ch_reg == atcc_pkg::CH_ESC) begin
                    ex_phase = atcc_pkg::ESC_SEEN;
                    handled  = 1'b1;
                end else begin
                    ex_phase = atcc_pkg::ESC_IDLE;
                end
            end
        endcase

        ex_new_r = home ? '0 : ex_cur_r;
        ex_new_c = home ? '0 : ex_cur_c;
        ex_w_r   = ex_cur_r;
        ex_w_c   = ex_cur_c;
        ex_w_g   = ch_reg;

        if (!handled) begin
            if (ch_reg == atcc_pkg::CH_NL) begin
                do_adv = 1'b1;
            end else if (ch_reg == atcc_pkg::CH_CR) begin
                ex_new_c = '0;
            end else if (ch_reg == atcc_pkg::CH_BS) begin
                if (ex_cur_c != '0) begin
                    ex_we    = 1'b1;
                    ex_w_c   = CW'(ex_cur_c - 1'b1);
                    ex_w_g   = atcc_pkg::CH_SPACE;
                    ex_new_c = CW'(ex_cur_c - 1'b1);
                end
            end else if (ch_reg >= atcc_pkg::CH_SPACE) begin
                ex_we = 1'b1;
                if (ex_cur_c == cols_last) begin
                    do_adv = 1'b1;
                end else begin
                    ex_new_c = CW'(ex_cur_c + 1'b1);
                end
            end
        end

        if (do_adv) begin
            ex_new_c = '0;
            if (ex_cur_r == rows_last) begin
                ex_scroll = 1'b1;
            end else begin
                ex_new_r = RW'(ex_cur_r + 1'b1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    logic          mem_we;
    logic [RW-1:0] mem_w_row;
    logic [CW-1:0] mem_w_col;
    logic [7:0]    mem_wdata;

    always_comb begin
        state_next         = state_reg;
        cursor_row_next    = cursor_row_reg;
        cursor_col_next    = cursor_col_reg;
        phase_next         = phase_reg;
        number_next        = number_reg;
        scan_row_next      = scan_row_reg;
        scan_col_next      = scan_col_reg;
        fill_row_last_next = fill_row_last_reg;
        fill_col_last_next = fill_col_last_reg;
        init_done_next     = init_done_reg;
        wr_pend_next       = 1'b0;
        m_tvalid_next      = m_tvalid_reg && !m_tready;
        mem_we             = 1'b0;
        mem_w_row          = wr_row_reg;
        mem_w_col          = wr_col_reg;
        mem_wdata          = rd_data_reg;

        // drain the delayed scroll copy first
        if (wr_pend_reg) begin
            mem_we = 1'b1;
        end

        unique case (state_reg)
            atcc_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = atcc_pkg::ST_EXEC;
                end
            end
            atcc_pkg::ST_EXEC: begin
                cursor_row_next    = ex_new_r;
                cursor_col_next    = ex_new_c;
                phase_next         = ex_phase;
                number_next        = ex_number;
                mem_we             = ex_we;
                mem_w_row          = ex_w_r;
                mem_w_col          = ex_w_c;
                mem_wdata          = ex_w_g;
                fill_row_last_next = rows_last;
                fill_col_last_next = cols_last;
                scan_col_next      = '0;
                if (ex_scroll) begin
                    if (rows_last == '0) begin
                        scan_row_next = '0;
                        state_next    = atcc_pkg::ST_FILL;
                    end else begin
                        scan_row_next = RW'(1);
                        state_next    = atcc_pkg::ST_SCROLL;
                    end
                end else if (ex_clear) begin
                    scan_row_next = '0;
                    state_next    = atcc_pkg::ST_FILL;
                end else begin
                    state_next = atcc_pkg::ST_DONE;
                end
            end
            atcc_pkg::ST_SCROLL: begin
                // read this cell now, write it one row up next cycle
                wr_pend_next = 1'b1;
                if (scan_col_reg == cols_last) begin
                    scan_col_next = '0;
                    if (scan_row_reg == rows_last) begin
                        state_next = atcc_pkg::ST_FILL;
                    end else begin
                        scan_row_next = RW'(scan_row_reg + 1'b1);
                    end
                end else begin
                    scan_col_next = CW'(scan_col_reg + 1'b1);
                end
            end
            atcc_pkg::ST_FILL: begin
                if (!wr_pend_reg) begin
                    mem_we    = 1'b1;
                    mem_w_row = scan_row_reg;
                    mem_w_col = scan_col_reg;
                    mem_wdata = atcc_pkg::CH_SPACE;
                    if (scan_col_reg == fill_col_last_reg) begin
                        scan_col_next = '0;
                        if (scan_row_reg == fill_row_last_reg) begin
                            init_done_next = 1'b1;
                            state_next     = init_done_reg ? atcc_pkg::ST_DONE
                                                           : atcc_pkg::ST_IDLE;
                        end else begin
                            scan_row_next = RW'(scan_row_reg + 1'b1);
                        end
                    end else begin
                        scan_col_next = CW'(scan_col_reg + 1'b1);
                    end
                end
            end
            atcc_pkg::ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    state_next    = atcc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = atcc_pkg::ST_IDLE;
            end
        endcase
    end

    assign s_tready  = (state_reg == atcc_pkg::ST_IDLE) && init_done_reg;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= atcc_pkg::ST_FILL;
            columns_in_use_reg <= atcc_pkg::COLUMNS_RESET;
            rows_in_use_reg    <= atcc_pkg::ROWS_RESET;
            cursor_row_reg     <= '0;
            cursor_col_reg     <= '0;
            phase_reg          <= atcc_pkg::ESC_IDLE;
            number_reg         <= '0;
            scan_row_reg       <= '0;
            scan_col_reg       <= '0;
            fill_row_last_reg  <= RW'(MAX_ROWS - 1);
            fill_col_last_reg  <= CW'(MAX_COLUMNS - 1);
            init_done_reg      <= 1'b0;
            wr_pend_reg        <= 1'b0;
            m_tvalid_reg       <= 1'b0;
        end else begin
            state_reg          <= state_next;
            cursor_row_reg     <= cursor_row_next;
            cursor_col_reg     <= cursor_col_next;
            phase_reg          <= phase_next;
            number_reg         <= number_next;
            scan_row_reg       <= scan_row_next;
            scan_col_reg       <= scan_col_next;
            fill_row_last_reg  <= fill_row_last_next;
            fill_col_last_reg  <= fill_col_last_next;
            init_done_reg      <= init_done_next;
            wr_pend_reg        <= wr_pend_next;
            m_tvalid_reg       <= m_tvalid_next;
            if (cfg_valid) begin
                unique case (cfg_index)
                    atcc_pkg::REG_COLUMNS_IN_USE: columns_in_use_reg <= cfg_data;
                    atcc_pkg::REG_ROWS_IN_USE:    rows_in_use_reg    <= cfg_data[6:0];
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            ch_reg <= s_tdata;
        end
        if (state_reg == atcc_pkg::ST_SCROLL) begin
            wr_row_reg <= RW'(scan_row_reg - 1'b1);
            wr_col_reg <= scan_col_reg;
        end
        if (state_reg == atcc_pkg::ST_EXEC) begin
            res_written_reg  <= ex_we;
            res_row_reg      <= ex_we ? atcc_pkg::ROW_OUT_W'(ex_w_r) : '0;
            res_col_reg      <= ex_we ? atcc_pkg::COL_OUT_W'(ex_w_c) : '0;
            res_glyph_reg    <= ex_we ? ex_w_g : '0;
            res_scrolled_reg <= ex_scroll;
            res_cleared_reg  <= ex_clear;
        end
        if (state_reg == atcc_pkg::ST_DONE && (!m_tvalid_reg || m_tready)) begin
            m_tuser_reg <= res_written_reg;
            m_tdata_reg <= {{atcc_pkg::M_TDATA_PAD{1'b0}},
                            atcc_pkg::COL_OUT_W'(cursor_col_reg),
                            atcc_pkg::ROW_OUT_W'(cursor_row_reg),
                            res_cleared_reg,
                            res_scrolled_reg,
                            res_glyph_reg,
                            res_col_reg,
                            res_row_reg};
        end
    end

    // ------------------------------------------------------------------
    // Cell memory: one write port, one registered read port
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            cell_mem[{mem_w_row, mem_w_col}] <= mem_wdata;
        end
        rd_data_reg <= cell_mem[{scan_row_reg, scan_col_reg}];
    end

`ifndef SYNTHESIS
    a_no_accept_before_init: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> init_done_reg)
        else $error("byte accepted before the reset fill finished");

    a_scroll_copy_rows_differ: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == atcc_pkg::ST_SCROLL) && wr_pend_reg |-> wr_row_reg != scan_row_reg)
        else $error("scroll copy writes the row being read");

    a_idle_write_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[20:0] == 21'd0)
        else $error("write fields set without a cell write");

    a_clear_excludes_write: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[22] |-> !m_tuser && !m_tdata[21])
        else $error("erase reported together with a write or scroll");

    a_scroll_column_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[21] |-> m_tdata[35:29] == 7'd0)
        else $error("scroll left the cursor off column zero");
`endif

endmodule
